>>> rtl/core/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg - shared types and constants of the max-heap priority queue
// Holds the capacity, the derived widths, operation and status codes, the
// sequencer states and the structs that pass between the modules.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CHD_W    = ADDR_W + 2;
  localparam int DATA_W   = 32;
  localparam int ENTRY_W  = 9;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_LOAD,
    ST_DN_CHK,
    ST_DN_L,
    ST_DN_R,
    ST_DN_CMP,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic                     func;
    logic signed [DATA_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic signed [DATA_W-1:0] top_value;
    logic                     heap_empty;
    logic [ENTRY_W-1:0]       entry_count;
    logic [1:0]               status;
  } out_res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic                     done;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] top;
    logic signed [DATA_W-1:0] popped;
    logic [1:0]               status;
  } ctrl_stat_t;

endpackage

>>> rtl/core/max_heap_priority_queue_top.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue_top - binary max-heap priority queue
// Push and pop requests on signed 32-bit values held as a complete binary
// tree in a RAM, with one result per request.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low;
// busy then stays high until the request has been fully worked through.
// Each request produces exactly one result, shown on out_res for a single
// cycle with out_strobe high. The strobe rises at the same edge at which busy
// falls, so the result sits in the first idle cycle. The receiver must take
// it in that cycle, as nothing holds it. The cost of a request is set by the
// sift loop, which visits one tree level per pass through the shared
// comparator and the single read port of the heap RAM. Each level that a
// push climbs takes a read of the parent and a compare; it ends on a write
// at the root or where it comes to rest. A pop first loads the moved value,
// then per level checks for children, reads the left child, reads the right
// child where there is one, and compares, ending on a write where the value
// comes to rest. A pop of the last value, a pop on an empty heap and a push
// on a full heap go straight to the response state; the last two report the
// matching status without touching the heap. The heap RAM needs no clearing
// after reset, since only values from slots below the fill count are used.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_top
  import mhpq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_data,
  output logic     out_strobe,
  output out_res_t out_res
);

  mem_req_t                 mem;
  logic [DATA_W-1:0]        rdata;
  logic signed [DATA_W-1:0] cmp_a, cmp_b;
  logic                     cmp_gt;
  ctrl_stat_t               stat;

  logic     out_strobe_r;
  out_res_t out_res_r, out_res_nxt;

  mhpq_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .req    (in_data),
    .busy   (busy),
    .mem    (mem),
    .rdata  (rdata),
    .cmp_a  (cmp_a),
    .cmp_b  (cmp_b),
    .cmp_gt (cmp_gt),
    .stat   (stat)
  );

  mhpq_cmp u_cmp (
    .op_a   (cmp_a),
    .op_b   (cmp_b),
    .a_gt_b (cmp_gt)
  );

  mhpq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .raddr (mem.raddr),
    .rdata (rdata)
  );

  // The result is formed from the sequencer's final state. The top value is
  // forced to zero whenever the heap is empty, since the root register then
  // holds a stale value; the count is reported modulo the field width.
  always_comb begin
    out_res_nxt.popped_value = stat.popped;
    out_res_nxt.top_value    = (stat.count == '0) ? '0 : stat.top;
    out_res_nxt.heap_empty   = (stat.count == '0);
    out_res_nxt.entry_count  = ENTRY_W'(stat.count);
    out_res_nxt.status       = stat.status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= stat.done;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule

>>> rtl/core/mhpq_ram.sv
// ----------------------------------------------------------------------------
// mhpq_ram - generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/mhpq_cmp.sv
// ----------------------------------------------------------------------------
// mhpq_cmp - shared signed compare unit
// Every ordering decision of both sift directions goes through this one unit.
// ----------------------------------------------------------------------------
module mhpq_cmp
  import mhpq_pkg::*;
(
  input  logic signed [DATA_W-1:0] op_a,
  input  logic signed [DATA_W-1:0] op_b,
  output logic                     a_gt_b
);

  assign a_gt_b = (op_a > op_b);

endmodule

>>> rtl/core/mhpq_ctrl.sv
// ----------------------------------------------------------------------------
// mhpq_ctrl - sift sequencer of the max-heap priority queue
// Walks the moving value up or down the tree one level at a time, keeping it
// in a register and writing it into the store only where it comes to rest.
// ----------------------------------------------------------------------------
module mhpq_ctrl
  import mhpq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  in_req_t                  req,
  output logic                     busy,
  output mem_req_t                 mem,
  input  logic [DATA_W-1:0]        rdata,
  output logic signed [DATA_W-1:0] cmp_a,
  output logic signed [DATA_W-1:0] cmp_b,
  input  logic                     cmp_gt,
  output ctrl_stat_t               stat
);

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [ADDR_W-1:0]        pos_r, pos_nxt;
  logic [ADDR_W-1:0]        pick_idx_r, pick_idx_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic signed [DATA_W-1:0] lval_r, lval_nxt;
  logic signed [DATA_W-1:0] pick_r, pick_nxt;
  logic signed [DATA_W-1:0] top_r, top_nxt;
  logic signed [DATA_W-1:0] popped_r, popped_nxt;
  logic [1:0]               status_r, status_nxt;

  logic signed [DATA_W-1:0] rd_s;
  logic [ADDR_W-1:0]        parent;
  logic [CHD_W-1:0]         lidx, ridx, n_ext;
  logic [CNT_W-1:0]         cnt_dec;

  assign rd_s    = $signed(rdata);
  assign parent  = (pos_r - ADDR_W'(1)) >> 1;
  assign lidx    = {1'b0, pos_r, 1'b1};
  assign ridx    = lidx + CHD_W'(1);
  assign n_ext   = CHD_W'(count_r);
  assign cnt_dec = count_r - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    pick_idx_r <= pick_idx_nxt;
    val_r      <= val_nxt;
    lval_r     <= lval_nxt;
    pick_r     <= pick_nxt;
    top_r      <= top_nxt;
    popped_r   <= popped_nxt;
    status_r   <= status_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    pos_nxt      = pos_r;
    pick_idx_nxt = pick_idx_r;
    val_nxt      = val_r;
    lval_nxt     = lval_r;
    pick_nxt     = pick_r;
    top_nxt      = top_r;
    popped_nxt   = popped_r;
    status_nxt   = status_r;
    mem          = '0;
    cmp_a        = val_r;
    cmp_b        = rd_s;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          status_nxt = STAT_OK;
          popped_nxt = '0;
          if (req.func == FUNC_PUSH) begin
            if (count_r == CNT_W'(CAPACITY)) begin
              status_nxt = STAT_FULL;
              state_nxt  = ST_RESP;
            end else begin
              val_nxt   = req.value;
              pos_nxt   = ADDR_W'(count_r);
              count_nxt = count_r + CNT_W'(1);
              state_nxt = ST_UP_RD;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = STAT_EMPTY;
              state_nxt  = ST_RESP;
            end else begin
              popped_nxt = top_r;
              count_nxt  = cnt_dec;
              pos_nxt    = '0;
              mem.raddr  = ADDR_W'(cnt_dec);
              state_nxt  = (cnt_dec == '0) ? ST_RESP : ST_DN_LOAD;
            end
          end
        end
      end

      ST_UP_RD: begin
        if (pos_r == '0) begin
          mem.we    = 1'b1;
          mem.waddr = '0;
          mem.wdata = val_r;
          top_nxt   = val_r;
          state_nxt = ST_RESP;
        end else begin
          mem.raddr = parent;
          state_nxt = ST_UP_CMP;
        end
      end

      ST_UP_CMP: begin
        // The new value rises past its parent only while strictly greater.
        cmp_a     = val_r;
        cmp_b     = rd_s;
        mem.we    = 1'b1;
        mem.waddr = pos_r;
        if (cmp_gt) begin
          mem.wdata = rdata;
          pos_nxt   = parent;
          state_nxt = ST_UP_RD;
        end else begin
          mem.wdata = val_r;
          state_nxt = ST_RESP;
        end
      end

      ST_DN_LOAD: begin
        val_nxt   = rd_s;
        state_nxt = ST_DN_CHK;
      end

      ST_DN_CHK: begin
        if (lidx >= n_ext) begin
          mem.we    = 1'b1;
          mem.waddr = pos_r;
          mem.wdata = val_r;
          if (pos_r == '0) begin
            top_nxt = val_r;
          end
          state_nxt = ST_RESP;
        end else begin
          mem.raddr = lidx[ADDR_W-1:0];
          state_nxt = ST_DN_L;
        end
      end

      ST_DN_L: begin
        lval_nxt     = rd_s;
        pick_nxt     = rd_s;
        pick_idx_nxt = lidx[ADDR_W-1:0];
        if (ridx < n_ext) begin
          mem.raddr = ridx[ADDR_W-1:0];
          state_nxt = ST_DN_R;
        end else begin
          state_nxt = ST_DN_CMP;
        end
      end

      ST_DN_R: begin
        // The right child wins only when strictly greater than the left.
        cmp_a = rd_s;
        cmp_b = lval_r;
        if (cmp_gt) begin
          pick_nxt     = rd_s;
          pick_idx_nxt = ridx[ADDR_W-1:0];
        end
        state_nxt = ST_DN_CMP;
      end

      ST_DN_CMP: begin
        cmp_a     = pick_r;
        cmp_b     = val_r;
        mem.we    = 1'b1;
        mem.waddr = pos_r;
        if (cmp_gt) begin
          mem.wdata = pick_r;
          if (pos_r == '0) begin
            top_nxt = pick_r;
          end
          pos_nxt   = pick_idx_r;
          state_nxt = ST_DN_CHK;
        end else begin
          mem.wdata = val_r;
          if (pos_r == '0) begin
            top_nxt = val_r;
          end
          state_nxt = ST_RESP;
        end
      end

      ST_RESP: begin
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy        = (state_r != ST_IDLE);
  assign stat.done   = (state_r == ST_RESP);
  assign stat.count  = count_r;
  assign stat.top    = top_r;
  assign stat.popped = popped_r;
  assign stat.status = status_r;

endmodule

>>> rtl/core/mhpq_chk.sv
// ----------------------------------------------------------------------------
// mhpq_chk - port-level checker for the max-heap priority queue
// Watches the request and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
module mhpq_chk
  import mhpq_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_strobe,
  input out_res_t out_res
);

  // An accepted request keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // A result follows directly on the end of a busy period.
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(busy) && !busy))
    else $error("result strobe without a finished request");

  // Results never arrive in two consecutive cycles.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("two results in consecutive cycles");

  // An empty heap reports no entries and a zero top value.
  a_empty_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_res.heap_empty) |->
      ((out_res.entry_count == '0) && (out_res.top_value == '0)))
    else $error("empty flag disagrees with count or top value");

  // A failed request removes nothing.
  a_failed_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_res.status != STAT_OK)) |->
      ((out_res.popped_value == '0) &&
       ((out_res.status == STAT_EMPTY) || (out_res.status == STAT_FULL))))
    else $error("failed request reports a popped value or bad status");

endmodule

bind max_heap_priority_queue_top mhpq_chk u_mhpq_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_res    (out_res)
);

>>> tb/max_heap_priority_queue_top_tb.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue_top_tb - self-checking bench for the max-heap queue
// Sends push and pop requests through the start/busy handshake. A short
// directed table comes first, then long random phases that fill the heap
// past capacity and drain it past empty. Each result is compared field by
// field with a predicted result from a behavioural heap kept in the bench.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_top_tb;
  import mhpq_pkg::*;

  // Random requests after the directed table.
  localparam int RANDOM_ITEMS   = 1750;
  // The slowest correct request is a deep pop, plus the longest sender gap
  // between bursts. The watchdog allows many times that.
  localparam int WATCHDOG_LIMIT = 2000;
  // Quiet cycles after the last result, long enough to catch a stray strobe.
  localparam int DRAIN_CYCLES   = 40;
  localparam int DIRECTED_ROWS  = 25;

  // One row of the directed table. Where typed is set, res is the exact
  // result; otherwise the behavioural heap supplies the expected result.
  typedef struct {
    logic                     func;
    logic signed [DATA_W-1:0] value;
    bit                       typed;
    out_res_t                 res;
  } stim_row_t;

  // Tag that travels with each request from the sender to the checker.
  typedef struct {
    bit       typed;
    out_res_t res;
  } typed_exp_t;

  // Shapes of random traffic: mostly pushes, balanced, mostly pops.
  typedef enum int {MIX_FILL, MIX_EVEN, MIX_DRAIN} mix_t;

  logic     clk;
  logic     rst_n   = 1'b0;
  logic     start   = 1'b0;
  logic     busy;
  in_req_t  in_data = '0;
  logic     out_strobe;
  out_res_t out_res;

  // Behavioural copy of the heap, used to predict every result.
  logic signed [DATA_W-1:0] heap_mem [CAPACITY];
  int unsigned              heap_fill = 0;

  out_res_t   pending_results [$];
  typed_exp_t typed_outcome   [$];
  int         error_count = 0;
  int         idle_cycles = 0;
  int         burst_left  = 0;

  // The directed table: extremes of the value field, the ignored value of
  // a pop, a pop on an empty heap, a pop that empties the heap, and ties.
  stim_row_t directed_table [DIRECTED_ROWS] = '{
    '{FUNC_POP,  32'sh0000_0000, 1'b1, '{32'sh0, 32'sh0, 1'b1, 9'd0, STAT_EMPTY}},
    '{FUNC_PUSH, 32'sh7FFF_FFFF, 1'b1, '{32'sh0, 32'sh7FFF_FFFF, 1'b0, 9'd1, STAT_OK}},
    '{FUNC_PUSH, 32'sh8000_0000, 1'b1, '{32'sh0, 32'sh7FFF_FFFF, 1'b0, 9'd2, STAT_OK}},
    '{FUNC_POP,  32'shFFFF_FFFF, 1'b1,
      '{32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 9'd1, STAT_OK}},
    '{FUNC_POP,  32'sh1234_5678, 1'b1, '{32'sh8000_0000, 32'sh0, 1'b1, 9'd0, STAT_OK}},
    '{FUNC_POP,  32'sh0000_0000, 1'b1, '{32'sh0, 32'sh0, 1'b1, 9'd0, STAT_EMPTY}},
    '{FUNC_PUSH, 32'sh0000_0000, 1'b1, '{32'sh0, 32'sh0, 1'b0, 9'd1, STAT_OK}},
    '{FUNC_PUSH, 32'shFFFF_FFFF, 1'b0, '0},
    '{FUNC_PUSH, 32'sh0000_0001, 1'b0, '0},
    '{FUNC_PUSH, 32'sh0000_0005, 1'b0, '0},
    '{FUNC_PUSH, 32'sh0000_0005, 1'b0, '0},
    '{FUNC_PUSH, 32'sh0000_0003, 1'b0, '0},
    '{FUNC_PUSH, 32'sh0000_0005, 1'b0, '0},
    '{FUNC_PUSH, 32'sh8000_0000, 1'b0, '0},
    '{FUNC_PUSH, 32'sh7FFF_FFFF, 1'b0, '0},
    '{FUNC_POP,  32'shAAAA_AAAA, 1'b0, '0},
    '{FUNC_POP,  32'sh5555_5555, 1'b0, '0},
    '{FUNC_POP,  32'sh0000_0000, 1'b0, '0},
    '{FUNC_POP,  32'sh0000_0000, 1'b0, '0},
    '{FUNC_POP,  32'sh0000_0000, 1'b0, '0},
    '{FUNC_POP,  32'sh0000_0000, 1'b0, '0},
    '{FUNC_POP,  32'sh0000_0000, 1'b0, '0},
    '{FUNC_POP,  32'sh0000_0000, 1'b0, '0},
    '{FUNC_POP,  32'sh0000_0000, 1'b0, '0},
    '{FUNC_POP,  32'sh0000_0000, 1'b1, '{32'sh0, 32'sh0, 1'b1, 9'd0, STAT_EMPTY}}
  };

  max_heap_priority_queue_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Applies one request to the behavioural heap and returns the result the
  // queue should report. A push on a full heap and a pop on an empty heap
  // leave the heap as it was.
  function automatic out_res_t heap_apply(input in_req_t req);
    out_res_t                 res;
    int unsigned              pos;
    int unsigned              up;
    int unsigned              lc;
    int unsigned              rc;
    int unsigned              pick;
    logic signed [DATA_W-1:0] tmp;
    res = '0;
    res.status = STAT_OK;
    if (req.func == FUNC_PUSH) begin
      if (heap_fill >= CAPACITY) begin
        res.status = STAT_FULL;
      end else begin
        pos = heap_fill;
        heap_mem[pos] = req.value;
        // Climb while strictly greater than the parent.
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (!(heap_mem[pos] > heap_mem[up])) break;
          tmp = heap_mem[pos];
          heap_mem[pos] = heap_mem[up];
          heap_mem[up] = tmp;
          pos = up;
        end
        heap_fill++;
      end
    end else if (heap_fill == 0) begin
      res.status = STAT_EMPTY;
    end else begin
      res.popped_value = heap_mem[0];
      heap_fill--;
      heap_mem[0] = heap_mem[heap_fill];
      pos = 0;
      // Descend towards the larger child, the left one on a tie, while that
      // child is strictly greater.
      forever begin
        lc = 2 * pos + 1;
        rc = lc + 1;
        if (lc >= heap_fill) break;
        pick = lc;
        if (rc < heap_fill && heap_mem[rc] > heap_mem[lc]) pick = rc;
        if (!(heap_mem[pick] > heap_mem[pos])) break;
        tmp = heap_mem[pos];
        heap_mem[pos] = heap_mem[pick];
        heap_mem[pick] = tmp;
        pos = pick;
      end
    end
    res.top_value   = (heap_fill != 0) ? heap_mem[0] : '0;
    res.heap_empty  = (heap_fill == 0);
    res.entry_count = ENTRY_W'(heap_fill);
    return res;
  endfunction

  task automatic compare_result(input out_res_t exp_res, input out_res_t got);
    if (got.popped_value !== exp_res.popped_value) begin
      $error("popped_value: expected %0d, got %0d", exp_res.popped_value, got.popped_value);
      error_count++;
    end
    if (got.top_value !== exp_res.top_value) begin
      $error("top_value: expected %0d, got %0d", exp_res.top_value, got.top_value);
      error_count++;
    end
    if (got.heap_empty !== exp_res.heap_empty) begin
      $error("heap_empty: expected %0b, got %0b", exp_res.heap_empty, got.heap_empty);
      error_count++;
    end
    if (got.entry_count !== exp_res.entry_count) begin
      $error("entry_count: expected %0d, got %0d", exp_res.entry_count, got.entry_count);
      error_count++;
    end
    if (got.status !== exp_res.status) begin
      $error("status: expected %0d, got %0d", exp_res.status, got.status);
      error_count++;
    end
  endtask

  // Result checker, request monitor and watchdog. Everything here reads the
  // values from before the clock edge, so the order of processes within a
  // time step does not matter. A result is checked before a request taken
  // at the same edge is predicted.
  always @(posedge clk) begin
    out_res_t   predicted;
    typed_exp_t tag;
    if (rst_n) begin
      if (out_strobe) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: %p", out_res);
          error_count++;
        end else begin
          compare_result(pending_results.pop_front(), out_res);
        end
      end
      if (start && !busy) begin
        predicted = heap_apply(in_data);
        if (typed_outcome.size() != 0) begin
          tag = typed_outcome.pop_front();
          pending_results.push_back(tag.typed ? tag.res : predicted);
        end else begin
          pending_results.push_back(predicted);
        end
      end
      if (out_strobe || (start && !busy)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL max_heap_priority_queue_top");
        $finish;
      end
    end
  end

  // Short bursts mostly, with now and then a long one so that runs of
  // back-to-back requests occur too.
  function automatic int pick_burst();
    if ($urandom_range(0, 3) == 0) return $urandom_range(40, 120);
    return $urandom_range(1, 12);
  endfunction

  // Values lean on the extremes and on a narrow band near zero, so that
  // equal keys meet often in the tree.
  function automatic logic signed [DATA_W-1:0] draw_value();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 4)  return 32'sh7FFF_FFFF;
    if (sel < 8)  return 32'sh8000_0000;
    if (sel < 11) return 32'sh0000_0000;
    if (sel < 14) return 32'shFFFF_FFFF;
    if (sel < 50) return DATA_W'($signed($urandom_range(0, 16)) - 8);
    return $urandom;
  endfunction

  // Presents one request and waits until it is taken. The start line stays
  // high into the next request inside a burst; between bursts it drops for
  // a random number of cycles, so that the next request lands on a
  // different phase of the queue's work.
  task automatic issue_request(input in_req_t req, input bit typed, input out_res_t res);
    typed_exp_t tag;
    tag.typed = typed;
    tag.res   = res;
    typed_outcome.push_back(tag);
    start   <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      burst_left = pick_burst();
    end
  endtask

  initial begin
    in_req_t     req;
    mix_t        mix;
    int unsigned push_pct;
    int          seg_left;
    int          phase;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    burst_left = pick_burst();

    foreach (directed_table[i]) begin
      req.func  = directed_table[i].func;
      req.value = directed_table[i].value;
      issue_request(req, directed_table[i].typed, directed_table[i].res);
    end

    // Random phases cycle through fill, balanced, drain and balanced. A fill
    // phase is long enough to reach capacity and then keep pushing into the
    // full heap; a drain phase likewise pops well past empty.
    phase    = 0;
    seg_left = 0;
    mix      = MIX_FILL;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (seg_left == 0) begin
        case (phase % 4)
          0: mix = MIX_FILL;
          2: mix = MIX_DRAIN;
          default: mix = MIX_EVEN;
        endcase
        seg_left = (mix == MIX_EVEN) ? $urandom_range(50, 200) : $urandom_range(320, 400);
        phase++;
      end
      seg_left--;
      case (mix)
        MIX_FILL:  push_pct = 95;
        MIX_DRAIN: push_pct = 5;
        default:   push_pct = 50;
      endcase
      req.func  = ($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP;
      // The value of a pop is ignored by the queue but is still driven with
      // random bits.
      req.value = (req.func == FUNC_PUSH) ? draw_value() : $urandom;
      issue_request(req, 1'b0, '0);
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS max_heap_priority_queue_top");
    end else begin
      $display("FAIL max_heap_priority_queue_top");
    end
    $finish;
  end

endmodule
